// ===== hw/rtl/ast_pkg.sv =====
// ----------------------------------------------------------------------------
// ast_pkg
// Shared types and constants for the aging station table: request kinds,
// controller states, slot entry layout and controller/datapath links.
// ----------------------------------------------------------------------------
package ast_pkg;

   localparam int SLOTS_DEFAULT = 16;

   localparam int ADDR_W = 48;
   localparam int MODE_W = 8;
   localparam int MEMB_W = 8;
   localparam int LIFE_W = 8;

   localparam int REQ_DATA_W = ADDR_W + MODE_W + MEMB_W;
   localparam int REQ_USER_W = 2;

   localparam int SLOT_OUT_W  = 4;
   localparam int COUNT_OUT_W = 5;
   localparam int RSP_DATA_W  = 16;

   localparam logic [LIFE_W-1:0] LIFETIME_RESET = 8'h96;

   typedef enum logic [REQ_USER_W-1:0] {
      REQ_BEACON     = 2'd0,
      REQ_TICK       = 2'd1,
      REQ_CLEAR_TBL  = 2'd2,
      REQ_CLEAR_FLAG = 2'd3
   } ast_req_kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_COMMIT,
      ST_RESP
   } ast_state_type;

   typedef struct packed {
      logic [LIFE_W-1:0] life;
      logic [MEMB_W-1:0] members;
      logic [MODE_W-1:0] mode;
      logic [ADDR_W-1:0] addr;
   } ast_entry_type;

   typedef struct packed {
      logic capture;     // take the request word
      logic scan_start;  // rewind scan pointer, clear search results
      logic scan_issue;  // read the slot under the scan pointer
      logic commit;      // apply the request to the table
      logic resp_load;   // load the response register
   } ast_cmd_type;

   typedef struct packed {
      logic scan_last;
      logic rsp_free;
   } ast_sts_type;

endpackage

// ===== hw/rtl/ast_ctrl.sv =====
// ----------------------------------------------------------------------------
// ast_ctrl
// Sequencer for the station table: accepts a request, steps the slot scan,
// commits the update and hands the response word to the output register.
// ----------------------------------------------------------------------------
module ast_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [ast_pkg::REQ_USER_W-1:0]  req_tuser,
   input  ast_pkg::ast_sts_type            sts,
   output ast_pkg::ast_cmd_type            cmd
);

   ast_pkg::ast_state_type state_ff;
   ast_pkg::ast_state_type state_in;
   ast_pkg::ast_req_kind_type kind;

   assign kind = ast_pkg::ast_req_kind_type'(req_tuser);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ast_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ast_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               // only beacons and ticks need to visit the slots
               if (kind == ast_pkg::REQ_BEACON || kind == ast_pkg::REQ_TICK) begin
                  state_in = ast_pkg::ST_SCAN;
               end else begin
                  state_in = ast_pkg::ST_COMMIT;
               end
            end
         end
         ast_pkg::ST_SCAN: begin
            if (sts.scan_last) begin
               state_in = ast_pkg::ST_DRAIN;
            end
         end
         ast_pkg::ST_DRAIN: begin
            state_in = ast_pkg::ST_COMMIT;
         end
         ast_pkg::ST_COMMIT: begin
            state_in = ast_pkg::ST_RESP;
         end
         ast_pkg::ST_RESP: begin
            if (sts.rsp_free) begin
               state_in = ast_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ast_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ast_pkg::ST_IDLE: begin
            req_tready     = 1'b1;
            cmd.capture    = req_tvalid;
            cmd.scan_start = req_tvalid;
         end
         ast_pkg::ST_SCAN: begin
            cmd.scan_issue = 1'b1;
         end
         ast_pkg::ST_DRAIN: begin
         end
         ast_pkg::ST_COMMIT: begin
            cmd.commit = 1'b1;
         end
         ast_pkg::ST_RESP: begin
            cmd.resp_load = sts.rsp_free;
         end
         default: begin
         end
      endcase
   end

endmodule

// ===== hw/rtl/ast_dpath.sv =====
// ----------------------------------------------------------------------------
// ast_dpath
// Slot storage and scan datapath: live bits, live count, change flag, the
// slot memory with its registered read, search results and response register.
// ----------------------------------------------------------------------------
module ast_dpath #(
   parameter int SLOTS = ast_pkg::SLOTS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [ast_pkg::LIFE_W-1:0]      csr_wr_data,
   input  logic [ast_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic [ast_pkg::REQ_USER_W-1:0]  req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [ast_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  ast_pkg::ast_cmd_type            cmd,
   output ast_pkg::ast_sts_type            sts
);

   localparam int IDX_W = $clog2(SLOTS);
   localparam int CNT_W = $clog2(SLOTS + 1);

   // configuration
   logic [ast_pkg::LIFE_W-1:0] lifetime_ff;
   logic [ast_pkg::LIFE_W-1:0] load_life;

   // captured request
   ast_pkg::ast_req_kind_type  kind_ff;
   logic [ast_pkg::ADDR_W-1:0] addr_ff;
   logic [ast_pkg::MODE_W-1:0] mode_ff;
   logic [ast_pkg::MEMB_W-1:0] memb_ff;

   // table state
   logic [SLOTS-1:0] live_ff, live_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             flag_ff, flag_in;

   ast_pkg::ast_entry_type mem [SLOTS];
   ast_pkg::ast_entry_type rd_data_ff;
   logic                   wr_en;
   logic [IDX_W-1:0]       wr_addr;
   ast_pkg::ast_entry_type wr_data;

   // scan pipeline
   logic [IDX_W-1:0] rd_idx_ff;
   logic             eval_valid_ff;
   logic [IDX_W-1:0] eval_idx_ff;
   logic             eval_live;
   logic [ast_pkg::LIFE_W-1:0] dec_life;

   // search results
   logic             hit_found_ff, hit_found_in;
   logic [IDX_W-1:0] hit_idx_ff, hit_idx_in;
   logic             free_found_ff, free_found_in;
   logic [IDX_W-1:0] free_idx_ff, free_idx_in;
   logic [IDX_W-1:0] sel_idx;
   logic             beacon;

   // response
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [ast_pkg::RSP_DATA_W-1:0] rsp_data_ff;
   logic [IDX_W+ast_pkg::SLOT_OUT_W-1:0]  slot_ext;
   logic [CNT_W+ast_pkg::COUNT_OUT_W-1:0] count_ext;
   logic [ast_pkg::SLOT_OUT_W-1:0]        rsp_slot;
   logic                                  rsp_hit;
   logic                                  rsp_stored;

   always_ff @(posedge clock) begin
      if (reset) begin
         lifetime_ff <= ast_pkg::LIFETIME_RESET;
      end else if (csr_wr_en) begin
         lifetime_ff <= csr_wr_data;
      end
   end

   // a zero lifetime is taken as one so a stored slot is always live
   assign load_life = (lifetime_ff == '0) ? ast_pkg::LIFE_W'(1) : lifetime_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff <= ast_pkg::ast_req_kind_type'(req_tuser);
         addr_ff <= req_tdata[ast_pkg::ADDR_W-1:0];
         mode_ff <= req_tdata[ast_pkg::ADDR_W +: ast_pkg::MODE_W];
         memb_ff <= req_tdata[ast_pkg::ADDR_W+ast_pkg::MODE_W +: ast_pkg::MEMB_W];
      end
   end

   assign beacon = (kind_ff == ast_pkg::REQ_BEACON);

   // scan pointer and read stage
   always_ff @(posedge clock) begin
      if (reset) begin
         eval_valid_ff <= 1'b0;
      end else begin
         eval_valid_ff <= cmd.scan_issue;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_start) begin
         rd_idx_ff <= '0;
      end else if (cmd.scan_issue) begin
         rd_idx_ff <= rd_idx_ff + IDX_W'(1);
      end
      eval_idx_ff <= rd_idx_ff;
   end

   assign sts.scan_last = (rd_idx_ff == IDX_W'(SLOTS - 1));

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_issue) begin
         rd_data_ff <= mem[rd_idx_ff];
      end
   end

   assign eval_live = live_ff[eval_idx_ff];
   assign dec_life  = rd_data_ff.life - ast_pkg::LIFE_W'(1);
   assign sel_idx   = hit_found_ff ? hit_idx_ff : free_idx_ff;

   // evaluate stage, commit and write port
   always_comb begin
      live_in       = live_ff;
      count_in      = count_ff;
      flag_in       = flag_ff;
      hit_found_in  = hit_found_ff;
      hit_idx_in    = hit_idx_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      wr_en         = 1'b0;
      wr_addr       = eval_idx_ff;
      wr_data       = rd_data_ff;

      if (cmd.scan_start) begin
         hit_found_in  = 1'b0;
         free_found_in = 1'b0;
      end

      if (eval_valid_ff) begin
         if (beacon) begin
            // lowest live match wins, else lowest free slot
            if (eval_live && rd_data_ff.addr == addr_ff && !hit_found_ff) begin
               hit_found_in = 1'b1;
               hit_idx_in   = eval_idx_ff;
            end
            if (!eval_live && !free_found_ff) begin
               free_found_in = 1'b1;
               free_idx_in   = eval_idx_ff;
            end
         end else if (eval_live) begin
            wr_en        = 1'b1;
            wr_data.life = dec_life;
            if (dec_life == '0) begin
               live_in[eval_idx_ff] = 1'b0;
               count_in             = count_ff - CNT_W'(1);
               flag_in              = 1'b1;
            end
         end
      end

      if (cmd.commit) begin
         case (kind_ff)
            ast_pkg::REQ_BEACON: begin
               wr_addr         = sel_idx;
               wr_data.life    = load_life;
               wr_data.members = memb_ff;
               wr_data.mode    = mode_ff;
               wr_data.addr    = addr_ff;
               if (hit_found_ff) begin
                  wr_en = 1'b1;
               end else if (free_found_ff) begin
                  wr_en            = 1'b1;
                  live_in[sel_idx] = 1'b1;
                  count_in         = count_ff + CNT_W'(1);
                  flag_in          = 1'b1;
               end
            end
            ast_pkg::REQ_CLEAR_TBL: begin
               live_in  = '0;
               count_in = '0;
            end
            ast_pkg::REQ_CLEAR_FLAG: begin
               flag_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff  <= '0;
         count_ff <= '0;
         flag_ff  <= 1'b0;
      end else begin
         live_ff  <= live_in;
         count_ff <= count_in;
         flag_ff  <= flag_in;
      end
   end

   always_ff @(posedge clock) begin
      hit_found_ff  <= hit_found_in;
      hit_idx_ff    <= hit_idx_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
   end

   // response word
   assign slot_ext   = {{ast_pkg::SLOT_OUT_W{1'b0}}, sel_idx};
   assign count_ext  = {{ast_pkg::COUNT_OUT_W{1'b0}}, count_ff};
   assign rsp_stored = beacon && (hit_found_ff || free_found_ff);
   assign rsp_hit    = beacon && hit_found_ff;
   assign rsp_slot   = rsp_stored ? slot_ext[ast_pkg::SLOT_OUT_W-1:0] : '0;

   assign sts.rsp_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.resp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.resp_load) begin
         rsp_data_ff <= {4'b0000, flag_ff, count_ext[ast_pkg::COUNT_OUT_W-1:0],
                         rsp_stored, rsp_hit, rsp_slot};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== hw/rtl/aging_station_table_unit.sv =====
// ----------------------------------------------------------------------------
// aging_station_table_unit
// Table of heard stations keyed by 48-bit address, with a lifetime counter
// per slot; beacons refresh or fill slots, ticks age them out.
//
//  port group   dir  payload
//  req_         in   tuser: kind; tdata: address, mode, member count
//  rsp_         out  tdata: slot, hit, stored, live count, change flag
//  csr_         in   8-bit entry lifetime, write only
//
// Beacon and tick words pass through accept, a scan with one slot read per
// cycle through the single read port of the slot memory, drain, commit and
// response; clear words skip the scan and drain. One word is worked on at a time.
// Reset empties every slot and clears the change flag at once.
// A stalled response holds the unit in its response step only if the
// output register is still occupied.
// ----------------------------------------------------------------------------
module aging_station_table_unit #(
   parameter int SLOTS = ast_pkg::SLOTS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [ast_pkg::LIFE_W-1:0]      csr_wr_data,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [47:0] station_address, [55:48] game_mode, [63:56] member_count
   input  logic [ast_pkg::REQ_DATA_W-1:0]  req_tdata,
   // [1:0] req_type
   input  logic [ast_pkg::REQ_USER_W-1:0]  req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [3:0] slot, [4] hit, [5] stored, [10:6] valid_count, [11] changed
   output logic [ast_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   ast_pkg::ast_cmd_type cmd;
   ast_pkg::ast_sts_type sts;

   ast_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .sts        (sts),
      .cmd        (cmd)
   );

   ast_dpath #(
      .SLOTS (SLOTS)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .cmd         (cmd),
      .sts         (sts)
   );

endmodule

// ===== tb/tb_aging_station_table_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_aging_station_table_unit
// Self-checking bench for the aging station table. A scoreboard holds its
// own copy of the slot table and the lifetime register, predicts the one
// response word of every accepted request and checks responses field by
// field in order. A directed opening covers hits, misses, refresh, expiry,
// a full table and both clears. Random phases then run under several
// lifetime settings and idling patterns.
// ----------------------------------------------------------------------------
module tb_aging_station_table_unit;

   localparam int TABLE_SLOTS  = ast_pkg::SLOTS_DEFAULT;
   localparam int ADDR_POOL    = 20;
   localparam int PHASE_WORDS  = 80;
   localparam int LIMIT_CYCLES = 400000;

   // response word, lowest field in the lowest bits
   typedef struct packed {
      logic                            changed;
      logic [ast_pkg::COUNT_OUT_W-1:0] live_count;
      logic                            stored;
      logic                            hit;
      logic [ast_pkg::SLOT_OUT_W-1:0]  slot;
   } station_outcome_type;

   class station_table_scoreboard;
      logic [ast_pkg::LIFE_W-1:0] life_left [TABLE_SLOTS];
      logic [ast_pkg::ADDR_W-1:0] held_addr [TABLE_SLOTS];
      logic                       change_flag;
      logic [ast_pkg::LIFE_W-1:0] lifetime_reg;
      station_outcome_type        expected_outcomes [$];
      int                         mismatches;

      // mode and member count are stored by the unit but never seen on rsp_
      function new();
         for (int i = 0; i < TABLE_SLOTS; i++) begin
            life_left[i] = '0;
            held_addr[i] = '0;
         end
         change_flag  = 1'b0;
         lifetime_reg = ast_pkg::LIFETIME_RESET;
         mismatches   = 0;
      endfunction

      function int outstanding();
         return expected_outcomes.size();
      endfunction

      function void note_request(ast_pkg::ast_req_kind_type kind,
                                 logic [ast_pkg::REQ_DATA_W-1:0] word);
         logic [ast_pkg::ADDR_W-1:0] addr;
         int                         found;
         int                         live;
         station_outcome_type        res;
         addr  = word[ast_pkg::ADDR_W-1:0];
         found = -1;
         live  = 0;
         res   = '0;
         case (kind)
            ast_pkg::REQ_BEACON: begin
               for (int i = 0; i < TABLE_SLOTS; i++)
                  if (found < 0 && life_left[i] != 0 && held_addr[i] == addr)
                     found = i;
               if (found >= 0) begin
                  res.hit = 1'b1;
               end else begin
                  for (int i = 0; i < TABLE_SLOTS; i++)
                     if (found < 0 && life_left[i] == 0)
                        found = i;
                  if (found >= 0)
                     change_flag = 1'b1;
               end
               if (found >= 0) begin
                  // a lifetime of zero loads as one
                  life_left[found] = (lifetime_reg == 0) ? ast_pkg::LIFE_W'(1)
                                                         : lifetime_reg;
                  held_addr[found] = addr;
                  res.slot   = found[ast_pkg::SLOT_OUT_W-1:0];
                  res.stored = 1'b1;
               end
            end
            ast_pkg::REQ_TICK: begin
               for (int i = 0; i < TABLE_SLOTS; i++)
                  if (life_left[i] != 0) begin
                     life_left[i] = life_left[i] - 1'b1;
                     if (life_left[i] == 0)
                        change_flag = 1'b1;
                  end
            end
            ast_pkg::REQ_CLEAR_TBL: begin
               for (int i = 0; i < TABLE_SLOTS; i++) begin
                  life_left[i] = '0;
                  held_addr[i] = '0;
               end
            end
            default: begin
               change_flag = 1'b0;
            end
         endcase
         for (int i = 0; i < TABLE_SLOTS; i++)
            if (life_left[i] != 0)
               live++;
         res.live_count = live[ast_pkg::COUNT_OUT_W-1:0];
         res.changed    = change_flag;
         expected_outcomes.push_back(res);
      endfunction

      task report_mismatch(string msg);
         mismatches++;
         $display("MISMATCH at %0t: %s", $realtime, msg);
      endtask

      task check_response(logic [ast_pkg::RSP_DATA_W-1:0] word);
         station_outcome_type got;
         station_outcome_type want;
         got = word[$bits(station_outcome_type)-1:0];
         if (expected_outcomes.size() == 0) begin
            report_mismatch($sformatf("response word %h with nothing outstanding", word));
            return;
         end
         want = expected_outcomes.pop_front();
         if (got.slot != want.slot)
            report_mismatch($sformatf("slot %0d, want %0d", got.slot, want.slot));
         if (got.hit != want.hit)
            report_mismatch($sformatf("hit %0b, want %0b", got.hit, want.hit));
         if (got.stored != want.stored)
            report_mismatch($sformatf("stored %0b, want %0b", got.stored, want.stored));
         if (got.live_count != want.live_count)
            report_mismatch($sformatf("live count %0d, want %0d",
                                      got.live_count, want.live_count));
         if (got.changed != want.changed)
            report_mismatch($sformatf("change flag %0b, want %0b",
                                      got.changed, want.changed));
      endtask
   endclass

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            csr_wr_en = 1'b0;
   logic [ast_pkg::LIFE_W-1:0]      csr_wr_data = '0;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [ast_pkg::REQ_DATA_W-1:0]  req_tdata = '0;
   logic [ast_pkg::REQ_USER_W-1:0]  req_tuser = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [ast_pkg::RSP_DATA_W-1:0]  rsp_tdata;

   station_table_scoreboard table_model;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;

   aging_station_table_unit uut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   always #2 clock = ~clock;

   always @(negedge clock) begin
      if (reset)
         rsp_tready <= 1'b0;
      else
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         table_model.check_response(rsp_tdata);
   end

   initial begin
      repeat (LIMIT_CYCLES) @(posedge clock);
      $display("tb_aging_station_table_unit: errors");
      $finish;
   end

   // entered and left just after a falling edge
   task automatic send_word(input ast_pkg::ast_req_kind_type kind,
                            input logic [ast_pkg::REQ_DATA_W-1:0] data);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      table_model.note_request(kind, data);
      @(negedge clock);
   endtask

   // only with the unit idle: every response has come back
   task automatic write_lifetime(input logic [ast_pkg::LIFE_W-1:0] value);
      req_tvalid <= 1'b0;
      while (table_model.outstanding() != 0) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      table_model.lifetime_reg = value;
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [ast_pkg::REQ_DATA_W-1:0] random_word();
      logic [63:0] r;
      r = {$urandom, $urandom};
      return r[ast_pkg::REQ_DATA_W-1:0];
   endfunction

   task automatic run_phase(input logic [ast_pkg::LIFE_W-1:0] lifetime,
                            input int sender_pct, input int stall_pct);
      logic [ast_pkg::ADDR_W-1:0]     pool [ADDR_POOL];
      logic [ast_pkg::REQ_DATA_W-1:0] word;
      ast_pkg::ast_req_kind_type      kind;
      int                             roll;
      write_lifetime(lifetime);
      send_idle_pct  = sender_pct;
      recv_stall_pct = stall_pct;
      // a pool a little larger than the table gives hits, misses and a full table
      for (int i = 0; i < ADDR_POOL; i++) begin
         word    = random_word();
         pool[i] = word[ast_pkg::ADDR_W-1:0];
      end
      repeat (PHASE_WORDS) begin
         roll = $urandom_range(99);
         if (roll < 58)
            kind = ast_pkg::REQ_BEACON;
         else if (roll < 90)
            kind = ast_pkg::REQ_TICK;
         else if (roll < 93)
            kind = ast_pkg::REQ_CLEAR_TBL;
         else
            kind = ast_pkg::REQ_CLEAR_FLAG;
         word = random_word();
         if ($urandom_range(9) != 0)
            word[ast_pkg::ADDR_W-1:0] = pool[$urandom_range(ADDR_POOL-1)];
         send_word(kind, word);
      end
   endtask

   initial begin
      table_model = new();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset lifetime: miss, second miss, refresh without a flag, plain tick
      send_word(ast_pkg::REQ_BEACON,     {8'h00, 8'h00, 48'h0});
      send_word(ast_pkg::REQ_BEACON,     {8'hFF, 8'hFF, 48'hFFFF_FFFF_FFFF});
      send_word(ast_pkg::REQ_CLEAR_FLAG, random_word());
      send_word(ast_pkg::REQ_BEACON,     {8'h5A, 8'hA5, 48'h0});
      send_word(ast_pkg::REQ_TICK,       random_word());

      // lifetime of one: fill the table, drop one, hit while full, expire
      write_lifetime(8'd1);
      for (int i = 0; i < TABLE_SLOTS - 2; i++)
         send_word(ast_pkg::REQ_BEACON, {8'(i), 8'(~i), 48'h5A5A_0000_0000 | 48'(i)});
      send_word(ast_pkg::REQ_BEACON,     {8'h11, 8'h22, 48'h1234_5678_9ABC});
      send_word(ast_pkg::REQ_BEACON,     {8'h33, 8'h44, 48'h0});
      send_word(ast_pkg::REQ_TICK,       random_word());
      send_word(ast_pkg::REQ_CLEAR_FLAG, random_word());
      send_word(ast_pkg::REQ_CLEAR_TBL,  random_word());

      run_phase(8'd1,   0,  0);
      run_phase(8'd255, 87, 0);
      run_phase(8'd0,   0,  87);
      run_phase(8'd3,   37, 37);
      run_phase(ast_pkg::LIFE_W'($urandom_range(6, 2)), 0, 0);
      run_phase(ast_pkg::LIFETIME_RESET, 37, 37);

      req_tvalid <= 1'b0;
      while (table_model.outstanding() != 0) @(negedge clock);
      // room for any stray response word
      repeat (2 * (TABLE_SLOTS + 4)) @(negedge clock);
      if (table_model.mismatches == 0)
         $display("tb_aging_station_table_unit: clean");
      else
         $display("tb_aging_station_table_unit: errors");
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/ast_pkg.sv
hw/rtl/ast_ctrl.sv
hw/rtl/ast_dpath.sv
hw/rtl/aging_station_table_unit.sv
tb/tb_aging_station_table_unit.sv
